FILE: rtl/spcs_pkg.sv
// ----------------------------------------------------------------------------
// spcs_pkg
// Shared types and constants of the sample phase calibration selector.
// ----------------------------------------------------------------------------
package spcs_pkg;

   // field widths of the item ports
   localparam int ERR_FIELD_BITS = 24;
   localparam int PHASE_BITS     = 3;
   localparam int LEAST_BITS     = 27;
   localparam int COUNT_BITS     = 4;
   localparam int LANE_FIELDS    = 6;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TELETEXT_MODE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_COUNT   = 1'd1;
   localparam logic [CSR_DATA_BITS-1:0]  PHASE_COUNT_RESET = 4'd6;

   // phase count limits and edge rule
   localparam logic [COUNT_BITS-1:0] MIN_PHASES = 4'd6;
   localparam logic [COUNT_BITS-1:0] MAX_PHASES = 4'd8;
   localparam logic [PHASE_BITS-1:0] EDGE_LOW   = 3'd1;
   localparam logic [PHASE_BITS-1:0] EDGE_HIGH  = 3'd6;
   localparam logic [PHASE_BITS-1:0] FLIP_MASK  = 3'd4;

   typedef logic [2:0] op_type;

   localparam op_type OP_NONE      = 3'd0;
   localparam op_type OP_LEAST     = 3'd1;
   localparam op_type OP_WIN_SHIFT = 3'd2;
   localparam op_type OP_WIN_EVAL  = 3'd3;
   localparam op_type OP_FLIP      = 3'd4;
   localparam op_type OP_OWN       = 3'd5;
   localparam op_type OP_LO        = 3'd6;
   localparam op_type OP_HI        = 3'd7;

   // controller -> datapath
   typedef struct packed {
      op_type                op;
      logic [PHASE_BITS-1:0] idx;    // row sum read address
      logic                  store;  // write the incoming row
      logic                  load;   // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [COUNT_BITS-1:0] phase_total;  // effective phase count
      logic                  row_ok;       // incoming row index is in range
   } status_type;

endpackage

FILE: rtl/spcs_ctrl.sv
// ----------------------------------------------------------------------------
// spcs_ctrl
// Sequencer: counts rows, steps the datapath through the search and owns
// both handshakes.
// ----------------------------------------------------------------------------
module spcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  spcs_pkg::status_type status,
   output spcs_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LEAST = 4'd1;
   localparam logic [3:0] S_WIN   = 4'd2;
   localparam logic [3:0] S_FLIP  = 4'd3;
   localparam logic [3:0] S_GAP   = 4'd4;
   localparam logic [3:0] S_OWN   = 4'd5;
   localparam logic [3:0] S_LO    = 4'd6;
   localparam logic [3:0] S_HI    = 4'd7;
   localparam logic [3:0] S_LAST  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0]                      state_ff, state_in;
   logic [spcs_pkg::COUNT_BITS-1:0] step_ff, step_in;
   logic [spcs_pkg::COUNT_BITS-1:0] rows_ff, rows_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [spcs_pkg::COUNT_BITS-1:0] rows_next;
   logic [spcs_pkg::COUNT_BITS-1:0] total;

   assign total     = status.phase_total;
   assign rows_next = rows_ff + spcs_pkg::COUNT_BITS'(1);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rows_in      = rows_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = spcs_pkg::OP_NONE;
      cmd.idx      = '0;
      cmd.store    = 1'b0;
      cmd.load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && status.row_ok) begin
               cmd.store = 1'b1;
               if (rows_next >= total) begin
                  rows_in  = '0;
                  step_in  = '0;
                  state_in = S_LEAST;
               end else begin
                  rows_in = rows_next;
               end
            end
         end
         S_LEAST: begin
            cmd.op  = spcs_pkg::OP_LEAST;
            cmd.idx = spcs_pkg::PHASE_BITS'(step_ff);
            if (step_ff == total - spcs_pkg::COUNT_BITS'(1)) begin
               step_in  = '0;
               state_in = S_WIN;
            end else begin
               step_in = step_ff + spcs_pkg::COUNT_BITS'(1);
            end
         end
         S_WIN: begin
            // stream sums n-1, 0, 1, .., n-1, 0 through a three-wide window
            cmd.op = (step_ff < spcs_pkg::COUNT_BITS'(2)) ? spcs_pkg::OP_WIN_SHIFT
                                                          : spcs_pkg::OP_WIN_EVAL;
            if (step_ff == '0) begin
               cmd.idx = spcs_pkg::PHASE_BITS'(total - spcs_pkg::COUNT_BITS'(1));
            end else if (step_ff == total + spcs_pkg::COUNT_BITS'(1)) begin
               cmd.idx = '0;
            end else begin
               cmd.idx = spcs_pkg::PHASE_BITS'(step_ff - spcs_pkg::COUNT_BITS'(1));
            end
            if (step_ff == total + spcs_pkg::COUNT_BITS'(1)) begin
               state_in = S_FLIP;
            end else begin
               step_in = step_ff + spcs_pkg::COUNT_BITS'(1);
            end
         end
         S_FLIP: begin
            cmd.op   = spcs_pkg::OP_FLIP;
            state_in = S_GAP;
         end
         S_GAP: begin
            state_in = S_OWN;
         end
         S_OWN: begin
            cmd.op   = spcs_pkg::OP_OWN;
            state_in = S_LO;
         end
         S_LO: begin
            cmd.op   = spcs_pkg::OP_LO;
            state_in = S_HI;
         end
         S_HI: begin
            cmd.op   = spcs_pkg::OP_HI;
            state_in = S_LAST;
         end
         S_LAST: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rows_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/spcs_datapath.sv
// ----------------------------------------------------------------------------
// spcs_datapath
// Row stores, least sum and window search, edge flip, per-lane refinement
// and the result register.
// ----------------------------------------------------------------------------
module spcs_datapath #(
   parameter int PHASE_ROWS = 8,
   parameter int LANES      = 6,
   parameter int ERROR_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic                                    csr_write,
   input  logic [spcs_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [spcs_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic [spcs_pkg::PHASE_BITS-1:0]         row_index,
   input  logic [spcs_pkg::LANE_FIELDS-1:0][spcs_pkg::ERR_FIELD_BITS-1:0] lane_in,
   input  spcs_pkg::cmd_type                       cmd,
   output spcs_pkg::status_type                    status,
   output logic [spcs_pkg::LANE_FIELDS-1:0][spcs_pkg::PHASE_BITS-1:0] phase_out,
   output logic                                    half_delay_out,
   output logic [spcs_pkg::PHASE_BITS-1:0]         base_out,
   output logic [spcs_pkg::LEAST_BITS-1:0]         least_out
);

   localparam int MEM_ROWS = (PHASE_ROWS < 8) ? PHASE_ROWS : 8;
   localparam int ROW_W    = $clog2(MEM_ROWS);
   localparam int USED     = (LANES < spcs_pkg::LANE_FIELDS) ? LANES : spcs_pkg::LANE_FIELDS;
   localparam int SUM_W    = ERROR_BITS + $clog2(USED + 1);
   localparam int WIN_W    = SUM_W + 2;
   localparam int VAL_W    = ERROR_BITS + 1;  // msb set: not available

   // configuration
   logic                                teletext_ff;
   logic [spcs_pkg::CSR_DATA_BITS-1:0]  phase_count_ff;
   logic [spcs_pkg::COUNT_BITS-1:0]     total;

   // stores
   logic [USED-1:0][ERROR_BITS-1:0] lane_mem [MEM_ROWS];
   logic [SUM_W-1:0]                sum_mem  [MEM_ROWS];
   logic [USED-1:0][ERROR_BITS-1:0] wr_row;
   logic [SUM_W-1:0]                wr_sum;

   // read side
   logic [USED-1:0][ERROR_BITS-1:0] lane_rd_ff;
   logic [SUM_W-1:0]                sum_rd_ff;
   spcs_pkg::op_type                op_d_ff;
   logic [spcs_pkg::PHASE_BITS-1:0] idx_d_ff;
   logic                            avail_d_ff;
   logic [spcs_pkg::COUNT_BITS-1:0] view_row;
   logic [spcs_pkg::PHASE_BITS-1:0] phys_row;
   logic                            avail;

   // search state
   logic [SUM_W-1:0]                least_ff;
   logic [SUM_W-1:0]                win_l_ff, win_c_ff;
   logic [spcs_pkg::PHASE_BITS-1:0] win_c_idx_ff;
   logic [WIN_W-1:0]                best_ff;
   logic                            found_ff;
   logic [WIN_W-1:0]                win_sum;
   logic [spcs_pkg::PHASE_BITS-1:0] base_ff;
   logic                            flip_ff;
   logic                            refine_ff;
   logic [USED-1:0][VAL_W-1:0]      own_ff, lo_ff, hi_ff;
   logic [USED-1:0][VAL_W-1:0]      rd_val;

   // result register
   logic [spcs_pkg::LANE_FIELDS-1:0][spcs_pkg::PHASE_BITS-1:0] phase_ff;
   logic [spcs_pkg::LANE_FIELDS-1:0][spcs_pkg::PHASE_BITS-1:0] phase_sel;
   logic                            half_ff;
   logic [spcs_pkg::PHASE_BITS-1:0] base_res_ff;
   logic [spcs_pkg::LEAST_BITS-1:0] least_res_ff;

   // effective phase count: clamp to 6..8, then to the store depth
   always_comb begin
      total = phase_count_ff;
      if (total < spcs_pkg::MIN_PHASES) total = spcs_pkg::MIN_PHASES;
      if (total > spcs_pkg::MAX_PHASES) total = spcs_pkg::MAX_PHASES;
      if (PHASE_ROWS < 8) begin
         if (total > spcs_pkg::COUNT_BITS'(MEM_ROWS)) total = spcs_pkg::COUNT_BITS'(MEM_ROWS);
      end
   end

   assign status.phase_total = total;
   assign status.row_ok      = {1'b0, row_index} < total;

   always_comb begin
      wr_sum = '0;
      for (int j = 0; j < USED; j++) begin
         wr_row[j] = ERROR_BITS'(lane_in[j]);
         wr_sum    = wr_sum + SUM_W'(wr_row[j]);
      end
   end

   // viewed row for the neighbour reads, then the stored row behind it
   always_comb begin
      view_row = {1'b0, base_ff};
      avail    = 1'b1;
      case (cmd.op)
         spcs_pkg::OP_LO: begin
            view_row = {1'b0, base_ff} - spcs_pkg::COUNT_BITS'(1);
            avail    = (base_ff != '0);
         end
         spcs_pkg::OP_HI: begin
            view_row = {1'b0, base_ff} + spcs_pkg::COUNT_BITS'(1);
            avail    = (view_row < total);
         end
         default: begin
            view_row = {1'b0, base_ff};
         end
      endcase
      phys_row = flip_ff ? (view_row[spcs_pkg::PHASE_BITS-1:0] ^ spcs_pkg::FLIP_MASK)
                         : view_row[spcs_pkg::PHASE_BITS-1:0];
      avail    = avail && ({1'b0, phys_row} < total);
   end

   assign win_sum = WIN_W'(win_l_ff) + WIN_W'(win_c_ff) + WIN_W'(sum_rd_ff);

   always_comb begin
      for (int j = 0; j < USED; j++) begin
         rd_val[j] = avail_d_ff ? {1'b0, lane_rd_ff[j]} : {1'b1, {ERROR_BITS{1'b0}}};
      end
   end

   // lanes step toward a strictly better neighbour when refinement is on
   always_comb begin
      for (int j = 0; j < spcs_pkg::LANE_FIELDS; j++) begin
         phase_sel[j] = base_ff;
      end
      for (int j = 0; j < USED; j++) begin
         if (refine_ff) begin
            if (lo_ff[j] < hi_ff[j] && lo_ff[j] < own_ff[j]) begin
               phase_sel[j] = base_ff - spcs_pkg::PHASE_BITS'(1);
            end else if (hi_ff[j] < lo_ff[j] && hi_ff[j] < own_ff[j]) begin
               phase_sel[j] = base_ff + spcs_pkg::PHASE_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         teletext_ff    <= 1'b0;
         phase_count_ff <= spcs_pkg::PHASE_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            spcs_pkg::REG_TELETEXT_MODE: begin
               teletext_ff <= csr_wdata[0];
            end
            spcs_pkg::REG_PHASE_COUNT: begin
               phase_count_ff <= csr_wdata;
            end
            default: begin
               phase_count_ff <= phase_count_ff;
            end
         endcase
      end
   end

   // stores: one row written per item, one row read per cycle
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         lane_mem[ROW_W'(row_index)] <= wr_row;
         sum_mem[ROW_W'(row_index)]  <= wr_sum;
      end
      lane_rd_ff <= lane_mem[ROW_W'(phys_row)];
      sum_rd_ff  <= sum_mem[ROW_W'(cmd.idx)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_d_ff <= spcs_pkg::OP_NONE;
      end else begin
         op_d_ff <= cmd.op;
      end
   end

   always_ff @(posedge clock) begin
      idx_d_ff   <= cmd.idx;
      avail_d_ff <= avail;
      case (op_d_ff)
         spcs_pkg::OP_LEAST: begin
            if (idx_d_ff == '0 || sum_rd_ff < least_ff) least_ff <= sum_rd_ff;
            found_ff <= 1'b0;
         end
         spcs_pkg::OP_WIN_SHIFT: begin
            win_l_ff     <= win_c_ff;
            win_c_ff     <= sum_rd_ff;
            win_c_idx_ff <= idx_d_ff;
         end
         spcs_pkg::OP_WIN_EVAL: begin
            if (win_c_ff == least_ff && (!found_ff || win_sum < best_ff)) begin
               best_ff  <= win_sum;
               base_ff  <= win_c_idx_ff;
               found_ff <= 1'b1;
            end
            win_l_ff     <= win_c_ff;
            win_c_ff     <= sum_rd_ff;
            win_c_idx_ff <= idx_d_ff;
         end
         spcs_pkg::OP_FLIP: begin
            refine_ff <= teletext_ff && (least_ff != '0);
            if (teletext_ff && least_ff != '0 &&
                (base_ff <= spcs_pkg::EDGE_LOW || base_ff >= spcs_pkg::EDGE_HIGH)) begin
               flip_ff <= 1'b1;
               base_ff <= base_ff ^ spcs_pkg::FLIP_MASK;
            end else begin
               flip_ff <= 1'b0;
            end
         end
         spcs_pkg::OP_OWN: own_ff <= rd_val;
         spcs_pkg::OP_LO:  lo_ff  <= rd_val;
         spcs_pkg::OP_HI:  hi_ff  <= rd_val;
         default: begin
            found_ff <= found_ff;
         end
      endcase
      if (cmd.load) begin
         phase_ff     <= phase_sel;
         half_ff      <= flip_ff;
         base_res_ff  <= base_ff;
         least_res_ff <= spcs_pkg::LEAST_BITS'(least_ff);
      end
   end

   assign phase_out      = phase_ff;
   assign half_delay_out = half_ff;
   assign base_out       = base_res_ff;
   assign least_out      = least_res_ff;

endmodule

FILE: rtl/sample_phase_calibration_select.sv
// ----------------------------------------------------------------------------
// sample_phase_calibration_select
// Collects error rows, one per sample phase, and once as many rows as the phase
// count are taken, picks a common sample phase and a refined phase per lane.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   req_    | in        | req_valid/req_ready  | row_index, lane_a..f_errors
//   rsp_    | out       | rsp_valid/rsp_ready  | phase_a..f, half_delay,
//           |           |                      | base_phase, least_sum
//   csr_    | in        | csr_write            | csr_index, csr_wdata
//
// A row is taken while the block is idle. The row that completes a calibration
// starts a search (N = phase count, 6 to 8), stepped by the single read
// port of each row store: N reads for the least sum, N+2 for the circular
// window, then three lane row reads for the neighbour refinement.
// No rows are taken during the search. A result waiting in the output
// register does not block new rows; only the next result load waits for it.
// Reset is synchronous; the stores are not cleared, and a calibration counts
// rows taken, not distinct rows, so a row not rewritten keeps older data.
//
module sample_phase_calibration_select #(
   parameter int PHASE_ROWS = 8,
   parameter int LANES      = 6,
   parameter int ERROR_BITS = 24
) (
   input  logic clock,
   input  logic reset,

   // configuration writes
   input  logic                                csr_write,
   input  logic [spcs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [spcs_pkg::CSR_DATA_BITS-1:0]  csr_wdata,

   // error rows
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [spcs_pkg::PHASE_BITS-1:0]     req_row_index,
   input  logic [spcs_pkg::ERR_FIELD_BITS-1:0] req_lane_a_errors,
   input  logic [spcs_pkg::ERR_FIELD_BITS-1:0] req_lane_b_errors,
   input  logic [spcs_pkg::ERR_FIELD_BITS-1:0] req_lane_c_errors,
   input  logic [spcs_pkg::ERR_FIELD_BITS-1:0] req_lane_d_errors,
   input  logic [spcs_pkg::ERR_FIELD_BITS-1:0] req_lane_e_errors,
   input  logic [spcs_pkg::ERR_FIELD_BITS-1:0] req_lane_f_errors,

   // calibration results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [spcs_pkg::PHASE_BITS-1:0]     rsp_phase_a,
   output logic [spcs_pkg::PHASE_BITS-1:0]     rsp_phase_b,
   output logic [spcs_pkg::PHASE_BITS-1:0]     rsp_phase_c,
   output logic [spcs_pkg::PHASE_BITS-1:0]     rsp_phase_d,
   output logic [spcs_pkg::PHASE_BITS-1:0]     rsp_phase_e,
   output logic [spcs_pkg::PHASE_BITS-1:0]     rsp_phase_f,
   output logic                                rsp_half_delay,
   output logic [spcs_pkg::PHASE_BITS-1:0]     rsp_base_phase,
   output logic [spcs_pkg::LEAST_BITS-1:0]     rsp_least_sum
);

   spcs_pkg::cmd_type    cmd;
   spcs_pkg::status_type status;

   // lane A sits at index 0
   logic [spcs_pkg::LANE_FIELDS-1:0][spcs_pkg::ERR_FIELD_BITS-1:0] lane_in;
   logic [spcs_pkg::LANE_FIELDS-1:0][spcs_pkg::PHASE_BITS-1:0]     phase_out;

   assign lane_in = {req_lane_f_errors, req_lane_e_errors, req_lane_d_errors,
                     req_lane_c_errors, req_lane_b_errors, req_lane_a_errors};

   // sequencer: row count, search steps, handshakes
   spcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, search registers and result register
   spcs_datapath #(
      .PHASE_ROWS (PHASE_ROWS),
      .LANES      (LANES),
      .ERROR_BITS (ERROR_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .row_index      (req_row_index),
      .lane_in        (lane_in),
      .cmd            (cmd),
      .status         (status),
      .phase_out      (phase_out),
      .half_delay_out (rsp_half_delay),
      .base_out       (rsp_base_phase),
      .least_out      (rsp_least_sum)
   );

   assign rsp_phase_a = phase_out[0];
   assign rsp_phase_b = phase_out[1];
   assign rsp_phase_c = phase_out[2];
   assign rsp_phase_d = phase_out[3];
   assign rsp_phase_e = phase_out[4];
   assign rsp_phase_f = phase_out[5];

endmodule

FILE: tb/tb_sample_phase_calibration_select.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_phase_calibration_select
// Self-checking bench for the sample phase calibration selector. Error rows
// go in through a randomly idling sender. A predictor keeps its
// own copy of the row stores and works out each calibration result. A
// randomly stalling receiver checks every result, field by field, against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sample_phase_calibration_select;

   // block constants, taken from the shared package
   localparam int PHASE_BITS     = spcs_pkg::PHASE_BITS;
   localparam int LANE_FIELDS    = spcs_pkg::LANE_FIELDS;
   localparam int ERR_FIELD_BITS = spcs_pkg::ERR_FIELD_BITS;
   localparam int LEAST_BITS     = spcs_pkg::LEAST_BITS;
   localparam int COUNT_BITS     = spcs_pkg::COUNT_BITS;
   localparam int CSR_INDEX_BITS = spcs_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS  = spcs_pkg::CSR_DATA_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TELETEXT_MODE = spcs_pkg::REG_TELETEXT_MODE;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_COUNT   = spcs_pkg::REG_PHASE_COUNT;
   localparam logic [CSR_DATA_BITS-1:0]  PHASE_COUNT_RESET = spcs_pkg::PHASE_COUNT_RESET;
   localparam logic [COUNT_BITS-1:0]     MIN_PHASES        = spcs_pkg::MIN_PHASES;
   localparam logic [COUNT_BITS-1:0]     MAX_PHASES        = spcs_pkg::MAX_PHASES;
   localparam logic [PHASE_BITS-1:0]     EDGE_LOW          = spcs_pkg::EDGE_LOW;
   localparam logic [PHASE_BITS-1:0]     EDGE_HIGH         = spcs_pkg::EDGE_HIGH;
   localparam logic [PHASE_BITS-1:0]     FLIP_MASK         = spcs_pkg::FLIP_MASK;

   localparam int ROWS          = 8;       // row store depth of the block
   localparam int ROW_TARGET    = 550;     // in-range rows to send in total
   localparam int SETTLE_CYCLES = 40;      // margin for a search to drain
   localparam int LONG_HOLD     = 300;     // receiver hold-off for back pressure
   localparam int CYCLE_LIMIT   = 400000;
   localparam longint unsigned NO_ERR = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum int {SHAPE_WIDE, SHAPE_TINY, SHAPE_VALLEY, SHAPE_PIT, SHAPE_MAX,
                     SHAPE_ZERO} row_shape_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0]                     row;
      logic [LANE_FIELDS-1:0][ERR_FIELD_BITS-1:0] errs;
   } error_row_type;

   typedef struct packed {
      logic [LANE_FIELDS-1:0][PHASE_BITS-1:0] phase;
      logic                                   half;
      logic [PHASE_BITS-1:0]                  base;
      logic [LEAST_BITS-1:0]                  least;
   } phase_choice_type;

   // ------------------------------------------------------------------------
   // DUT inputs, all at known values from time zero
   // ------------------------------------------------------------------------
   logic clock;
   logic reset = 1'b1;

   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic                      req_valid         = 1'b0;
   logic                      req_ready;
   logic [PHASE_BITS-1:0]     req_row_index     = '0;
   logic [ERR_FIELD_BITS-1:0] req_lane_a_errors = '0;
   logic [ERR_FIELD_BITS-1:0] req_lane_b_errors = '0;
   logic [ERR_FIELD_BITS-1:0] req_lane_c_errors = '0;
   logic [ERR_FIELD_BITS-1:0] req_lane_d_errors = '0;
   logic [ERR_FIELD_BITS-1:0] req_lane_e_errors = '0;
   logic [ERR_FIELD_BITS-1:0] req_lane_f_errors = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PHASE_BITS-1:0]     rsp_phase_a, rsp_phase_b, rsp_phase_c;
   logic [PHASE_BITS-1:0]     rsp_phase_d, rsp_phase_e, rsp_phase_f;
   logic                      rsp_half_delay;
   logic [PHASE_BITS-1:0]     rsp_base_phase;
   logic [LEAST_BITS-1:0]     rsp_least_sum;

   sample_phase_calibration_select dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_row_index     (req_row_index),
      .req_lane_a_errors (req_lane_a_errors),
      .req_lane_b_errors (req_lane_b_errors),
      .req_lane_c_errors (req_lane_c_errors),
      .req_lane_d_errors (req_lane_d_errors),
      .req_lane_e_errors (req_lane_e_errors),
      .req_lane_f_errors (req_lane_f_errors),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_phase_a       (rsp_phase_a),
      .rsp_phase_b       (rsp_phase_b),
      .rsp_phase_c       (rsp_phase_c),
      .rsp_phase_d       (rsp_phase_d),
      .rsp_phase_e       (rsp_phase_e),
      .rsp_phase_f       (rsp_phase_f),
      .rsp_half_delay    (rsp_half_delay),
      .rsp_base_phase    (rsp_base_phase),
      .rsp_least_sum     (rsp_least_sum)
   );

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   error_row_type    pending_rows[$];       // rows waiting for the driver
   phase_choice_type expected_choices[$];   // predicted results, oldest first
   error_row_type    offered_row;           // row currently on the req_ port
   phase_choice_type seen_choice;

   // predictor copy of the block state and its registers
   logic [ERR_FIELD_BITS-1:0] err_mem [ROWS][LANE_FIELDS];
   logic [LEAST_BITS-1:0]     sum_mem [ROWS];
   logic [COUNT_BITS-1:0]     rows_taken = '0;
   logic                      cfg_teletext = 1'b0;
   logic [COUNT_BITS-1:0]     cfg_count = PHASE_COUNT_RESET;

   // rows that hold data already; a calibration may only read these
   bit row_filled [ROWS];
   int rows_in_range = 0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit rx_hold_on     = 1'b0;
   int hold_count     = 0;
   int fails          = 0;
   int cycle_count    = 0;

   // ------------------------------------------------------------------------
   // Clock and run limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   // effective phase count: register saturated to the 6..8 range
   function automatic int active_phases(logic [COUNT_BITS-1:0] setting);
      int k;
      k = int'(setting);
      if (k < int'(MIN_PHASES)) k = int'(MIN_PHASES);
      if (k > int'(MAX_PHASES)) k = int'(MAX_PHASES);
      if (k > ROWS) k = ROWS;
      return k;
   endfunction

   // lane error at a viewed phase; rows past the measured ones never win
   function automatic longint unsigned lane_view(int v, int lane, bit flip, int n);
      int p;
      p = flip ? (v ^ int'(FLIP_MASK)) : v;
      if (p >= n) return NO_ERR;
      return err_mem[p][lane];
   endfunction

   task automatic take_error_row(input error_row_type it);
      int n, i, j, l, r, base, v;
      longint unsigned total, least, best, w, own, lo, hi;
      bit flip;
      phase_choice_type c;
      n = active_phases(cfg_count);
      if (it.row >= n) return;          // out-of-range rows are dropped
      total = 0;
      for (j = 0; j < LANE_FIELDS; j++) begin
         err_mem[it.row][j] = it.errs[j];
         total += it.errs[j];
      end
      sum_mem[it.row] = total[LEAST_BITS-1:0];
      rows_taken = rows_taken + 1'b1;
      if (rows_taken < n) return;
      rows_taken = '0;

      least = NO_ERR;
      for (i = 0; i < n; i++)
         if (sum_mem[i] < least) least = sum_mem[i];
      // circular 3-phase window among the least-sum phases, first one wins a tie
      best = NO_ERR;
      base = 0;
      for (i = 0; i < n; i++) begin
         l = (i + n - 1) % n;
         r = (i + 1) % n;
         w = longint'(sum_mem[l]) + sum_mem[i] + sum_mem[r];
         if (sum_mem[i] == least && w < best) begin
            best = w;
            base = i;
         end
      end
      // teletext edge case: half delay and the view turned by four phases
      flip = 1'b0;
      if (cfg_teletext && least > 0 &&
          (base <= int'(EDGE_LOW) || base >= int'(EDGE_HIGH))) begin
         flip = 1'b1;
         base = (base ^ int'(FLIP_MASK)) & 7;
      end
      // per-lane step toward a strictly better neighbour
      for (j = 0; j < LANE_FIELDS; j++) begin
         v = base;
         if (cfg_teletext && least > 0) begin
            own = lane_view(v, j, flip, n);
            lo  = (v > 0) ? lane_view(v - 1, j, flip, n) : NO_ERR;
            hi  = (v + 1 < n) ? lane_view(v + 1, j, flip, n) : NO_ERR;
            if (lo < hi && lo < own) v = v - 1;
            else if (hi < lo && hi < own) v = v + 1;
         end
         c.phase[j] = 3'(v);
      end
      c.half  = flip;
      c.base  = 3'(base);
      c.least = least[LEAST_BITS-1:0];
      expected_choices.push_back(c);
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers queued rows, idles at random between them
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) take_error_row(offered_row);
         // slot is free when nothing is offered or the offer just went in
         if (!req_valid || req_ready) begin
            if (pending_rows.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_row = pending_rows.pop_front();
               req_row_index     <= offered_row.row;
               req_lane_a_errors <= offered_row.errs[0];
               req_lane_b_errors <= offered_row.errs[1];
               req_lane_c_errors <= offered_row.errs[2];
               req_lane_d_errors <= offered_row.errs[3];
               req_lane_e_errors <= offered_row.errs[4];
               req_lane_f_errors <= offered_row.errs[5];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: random stalls, long hold-off on request, field checks
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rx_hold_on) hold_count <= hold_count + 1;
      else hold_count <= 0;
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_choices.size() == 0) begin
               $error("result with no calibration pending: base_phase %0d, least_sum %0d",
                      rsp_base_phase, rsp_least_sum);
               fails++;
            end else begin
               seen_choice = expected_choices.pop_front();
               check_field("phase_a", seen_choice.phase[0], rsp_phase_a);
               check_field("phase_b", seen_choice.phase[1], rsp_phase_b);
               check_field("phase_c", seen_choice.phase[2], rsp_phase_c);
               check_field("phase_d", seen_choice.phase[3], rsp_phase_d);
               check_field("phase_e", seen_choice.phase[4], rsp_phase_e);
               check_field("phase_f", seen_choice.phase[5], rsp_phase_f);
               check_field("half_delay", seen_choice.half, rsp_half_delay);
               check_field("base_phase", seen_choice.base, rsp_base_phase);
               check_field("least_sum", seen_choice.least, rsp_least_sum);
            end
         end
         rsp_ready <= !(rx_hold_on && hold_count < LONG_HOLD) &&
                      ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // one lane error for a row; valley shapes dip around the center phase
   function automatic logic [ERR_FIELD_BITS-1:0] lane_error(row_shape_type shape,
                                                            int row, int center, int n);
      int d;
      d = (row - center + n) % n;
      if (n - d < d) d = n - d;
      case (shape)
         SHAPE_WIDE: begin
            case ($urandom_range(15))
               0: return '0;
               1: return '1;
               default: return ERR_FIELD_BITS'($urandom);
            endcase
         end
         SHAPE_TINY: return ERR_FIELD_BITS'($urandom_range(3));
         SHAPE_MAX:  return '1;
         SHAPE_ZERO: return '0;
         SHAPE_PIT:
            if (d == 0) return '0;
            else return ERR_FIELD_BITS'(d * $urandom_range(64, 4000) + $urandom_range(63));
         default:
            return ERR_FIELD_BITS'(d * $urandom_range(64, 4000) + $urandom_range(63));
      endcase
   endfunction

   // queues one full calibration: each measured phase once, optionally
   // shuffled, with one phase repeated, and with ignored rows mixed in
   task automatic queue_calibration(row_shape_type shape, int center, bit shuffle,
                                    bit dup, int noise_pct);
      int n, i, k, t, drop, keep;
      int order [ROWS];
      error_row_type it;
      n = active_phases(cfg_count);
      for (i = 0; i < n; i++) order[i] = i;
      if (shuffle) begin
         for (i = n - 1; i > 0; i--) begin
            k = $urandom_range(i);
            t = order[i];
            order[i] = order[k];
            order[k] = t;
         end
      end
      // a repeated phase leaves another one out, so that one must hold data
      if (dup) begin
         drop = $urandom_range(n - 1);
         if (row_filled[drop]) begin
            keep = (drop + 1 + $urandom_range(n - 2)) % n;
            for (i = 0; i < n; i++)
               if (order[i] == drop) order[i] = keep;
         end
      end
      for (i = 0; i < n; i++) begin
         if (n < ROWS && $urandom_range(99) < noise_pct) begin
            it.row = 3'($urandom_range(ROWS - 1, n));
            for (k = 0; k < LANE_FIELDS; k++) it.errs[k] = ERR_FIELD_BITS'($urandom);
            pending_rows.push_back(it);
         end
         it.row = 3'(order[i]);
         for (k = 0; k < LANE_FIELDS; k++) it.errs[k] = lane_error(shape, order[i], center, n);
         pending_rows.push_back(it);
         row_filled[order[i]] = 1'b1;
         rows_in_range++;
      end
   endtask

   // waits until everything sent has been answered, then lets a search drain
   task automatic wait_quiet();
      @(negedge clock);
      while (pending_rows.size() > 0 || req_valid || expected_choices.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == REG_TELETEXT_MODE) cfg_teletext = val[0];
      else cfg_count = val;
   endtask

   function automatic row_shape_type random_shape();
      int r;
      r = $urandom_range(19);
      if (r < 10) return SHAPE_VALLEY;
      if (r < 12) return SHAPE_PIT;
      if (r < 17) return SHAPE_WIDE;
      return SHAPE_TINY;
   endfunction

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : sequencer
      int m, k;
      logic [CSR_DATA_BITS-1:0] count_val;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: six phases, plain mode; every field at its maximum
      // so all sums and windows tie and the first phase must win; rows past
      // the phase count are mixed in and must be ignored
      queue_calibration(SHAPE_MAX, 0, 1'b0, 1'b0, 40);
      wait_quiet();

      // teletext on (upper data bits set), count 0 saturates up to 6;
      // all-zero rows keep the least sum at zero, one phase repeated
      write_reg(REG_TELETEXT_MODE, 4'hF);
      write_reg(REG_PHASE_COUNT, 4'd0);
      queue_calibration(SHAPE_ZERO, 0, 1'b0, 1'b1, 40);
      wait_quiet();

      // count 15 saturates down to 8; minimum at the last phase takes
      // the edge flip with half delay and the refined lane view
      write_reg(REG_PHASE_COUNT, 4'd15);
      queue_calibration(SHAPE_VALLEY, 7, 1'b0, 1'b0, 0);
      wait_quiet();

      // receiver holds off while the sender keeps offering, so a result
      // sits in the output register and the next search backs up the input
      write_reg(REG_PHASE_COUNT, 4'd6);
      rx_hold_on = 1'b1;
      for (k = 0; k < 3; k++)
         queue_calibration(SHAPE_VALLEY, $urandom_range(5), 1'b0, 1'b0, 0);
      while (hold_count < LONG_HOLD) @(negedge clock);
      rx_hold_on = 1'b0;
      // sender pauses until every result has drained
      wait_quiet();

      // random part, walking through the idle profiles
      while (rows_in_range < ROW_TARGET) begin
         m = rows_in_range * 4 / ROW_TARGET;
         case (m)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         case ($urandom_range(7))
            0:       count_val = 4'd0;
            1:       count_val = 4'd5;
            2:       count_val = 4'd6;
            3:       count_val = 4'd7;
            4:       count_val = 4'd8;
            5:       count_val = 4'd9;
            6:       count_val = 4'd15;
            default: count_val = 4'($urandom);
         endcase
         write_reg(REG_TELETEXT_MODE, {3'($urandom), $urandom_range(9) < 7});
         write_reg(REG_PHASE_COUNT, count_val);
         @(negedge clock);
         for (k = 0; k < 4; k++)
            queue_calibration(random_shape(), $urandom_range(7) % active_phases(cfg_count),
                              $urandom_range(7) == 0, $urandom_range(7) == 0, 15);
         wait_quiet();
      end

      wait_quiet();
      if (fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/spcs_pkg.sv
rtl/spcs_ctrl.sv
rtl/spcs_datapath.sv
rtl/sample_phase_calibration_select.sv
tb/tb_sample_phase_calibration_select.sv
